// ===== hw/rtl/dic_pkg.sv =====
// Shared constants and types for the dynamic inversion counter.
`default_nettype none

package dic_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int VAL_W        = 11;
	localparam int OUT_W        = 19;

	// largest possible total: every pair inverted
	localparam longint unsigned TOT_MAX =
		longint'(MAX_ELEMENTS) * longint'(MAX_ELEMENTS - 1) / 2;
	localparam int TOT_W = $clog2(TOT_MAX + 1);
	localparam int SUM_W = (TOT_W > CNT_W + 1) ? TOT_W : CNT_W + 1;
	localparam int CMP_W = (TOT_W > OUT_W) ? TOT_W : OUT_W;

	localparam int DATA_IN_W  = 16;
	localparam int USER_IN_W  = 2;
	localparam int DATA_OUT_W = 24;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef struct packed {
		logic             active;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            entry;
	} store_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dynamic_inversion_counter.sv =====
// Top level: sequencer scanning the entry store with one shared compare and count unit.
// An accepted load or delete scans the c stored entries over the single read port, then
// passes the drain and commit states; a delete then places its word in the output register
// in the push state, waiting while a pending word is not taken; only idle accepts a word.
// A load with first set or into an empty store skips the scan; a full store drops a load.
// Reset clears entry count, total and handshake state; store contents stay, entries at or
// above the count are never read.
`default_nettype none

module dynamic_inversion_counter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [dic_pkg::DATA_IN_W-1:0] s_tdata,  // value[10:0]
	input  wire logic [dic_pkg::USER_IN_W-1:0] s_tuser,  // action[0], first[1]
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [dic_pkg::DATA_OUT_W-1:0]     m_tdata   // inversion_total[18:0]
);
	import dic_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;
	localparam logic [2:0] ST_PUSH  = 3'd4;

	logic [2:0]        state_q;
	logic              op_q;
	logic [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]  count_q;
	logic [TOT_W-1:0]  total_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] pos_q;
	logic              found_q;
	logic [CNT_W-1:0]  gt_cnt_q;
	logic [CNT_W-1:0]  lt_cnt_q;
	logic [OUT_W-1:0]  rep_q;
	logic [OUT_W-1:0]  res_q;
	logic              m_valid_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr_s1;

	store_wr_t         wr;
	entry_t            rd_entry;
	logic              in_acc;
	logic              in_op;
	logic              in_first;
	logic              cmp_gt;
	logic              cmp_eq;
	logic              cmp_lt;
	logic              last_addr;
	logic [SUM_W-1:0]  tot_ext;
	logic [SUM_W-1:0]  sub_ext;
	logic [SUM_W-1:0]  add_sum;
	logic [SUM_W-1:0]  sub_res;
	logic [OUT_W-1:0]  rep_sat;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_op    = s_tuser[0];
	assign in_first = s_tuser[1];

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(DATA_OUT_W - OUT_W){1'b0}}, res_q};

	// shared compare against the held query value
	assign cmp_gt = rd_entry.value > val_q;
	assign cmp_eq = rd_entry.value == val_q;
	assign cmp_lt = rd_entry.value < val_q;

	assign last_addr = (CNT_W'(addr_q) + CNT_W'(1)) == count_q;

	assign tot_ext = SUM_W'(total_q);
	assign sub_ext = SUM_W'(gt_cnt_q) + SUM_W'(lt_cnt_q);
	assign add_sum = tot_ext + SUM_W'(gt_cnt_q);
	assign sub_res = (sub_ext <= tot_ext) ? tot_ext - sub_ext : '0;

	assign rep_sat = (CMP_W'(total_q) > CMP_W'(OUT_W'({OUT_W{1'b1}}))) ?
		{OUT_W{1'b1}} : OUT_W'(total_q);

	always_comb begin
		wr.en          = (state_q == ST_DONE) && ((op_q == ACT_LOAD) || found_q);
		wr.addr        = (op_q == ACT_LOAD) ? count_q[ADDR_W-1:0] : pos_q;
		wr.entry.active = (op_q == ACT_LOAD);
		wr.entry.value = val_q;
	end

	dic_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (addr_q),
		.rd_data (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			total_q   <= '0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			// the push state refills the output register itself
			if (m_valid_q && m_tready && (state_q != ST_PUSH)) begin
				m_valid_q <= 1'b0;
			end

			// count unit: greater before the match, smaller after it
			if (rd_vld_s1 && rd_entry.active) begin
				if ((op_q == ACT_DELETE) && !found_q && cmp_eq) begin
					found_q <= 1'b1;
				end else if (!found_q && cmp_gt) begin
					gt_cnt_q <= gt_cnt_q + CNT_W'(1);
				end else if (found_q && cmp_lt) begin
					lt_cnt_q <= lt_cnt_q + CNT_W'(1);
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= in_op;
						val_q    <= s_tdata[VAL_W-1:0];
						addr_q   <= '0;
						found_q  <= 1'b0;
						gt_cnt_q <= '0;
						lt_cnt_q <= '0;
						rep_q    <= rep_sat;
						if (in_op == ACT_LOAD && in_first) begin
							count_q <= '0;
							total_q <= '0;
							state_q <= ST_DONE;
						end else if (in_op == ACT_LOAD &&
							count_q == CNT_W'(MAX_ELEMENTS)) begin
							state_q <= ST_IDLE;
						end else if (count_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last_addr) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (op_q == ACT_LOAD) begin
						count_q <= count_q + CNT_W'(1);
						total_q <= TOT_W'(add_sum);
						state_q <= ST_IDLE;
					end else begin
						if (found_q) begin
							total_q <= TOT_W'(sub_res);
						end
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q;
		if (rd_vld_s1 && rd_entry.active && (op_q == ACT_DELETE) && !found_q && cmp_eq) begin
			pos_q <= rd_addr_s1;
		end
		if (state_q == ST_PUSH && (!m_valid_q || m_tready)) begin
			res_q <= rep_q;
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("entry count above store depth");

	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("read data outside scan");

	a_found_delete: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && state_q != ST_IDLE) |-> (op_q == ACT_DELETE))
		else $error("match flag set on a load");

	a_done_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (state_q == ST_IDLE || state_q == ST_PUSH))
		else $error("bad state after commit");

	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> $stable(res_q))
		else $error("pending word overwritten");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/dic_store.sv =====
// Entry store: value and active flag per position, one write and one registered read port.
`default_nettype none

module dic_store (
	input  wire logic                      clk,
	input  wire dic_pkg::store_wr_t        wr,
	input  wire logic                      rd_en,
	input  wire logic [dic_pkg::ADDR_W-1:0] rd_addr,
	output dic_pkg::entry_t                rd_data
);
	import dic_pkg::*;

	entry_t mem_q [MAX_ELEMENTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
